// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the top level of the key sequence matcher.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ----- rtl/core/kseq_pkg.sv -----
// Package with the constants, types and helper functions of the key sequence matcher.
`default_nettype none

package kseq_pkg;

    // Sizes of the pattern store and slot state.
    localparam int NUM_PAT     = 8;
    localparam int SLOT_W      = 3;
    localparam int MAX_LEN     = 16;
    localparam int POS_W       = 4;
    localparam int MEM_DEPTH   = NUM_PAT * MAX_LEN;
    localparam int MEM_AW      = SLOT_W + POS_W;
    localparam int CHAR_W      = 8;
    localparam int ARG_W       = 4;
    localparam int ARG_SLOTS   = 2;
    localparam int CC_W        = 2;
    localparam int CNT_W       = 4;
    localparam int MAX_RESULTS = 8;

    // Character codes.
    localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_LOW_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOW_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CASE_OFS = 8'd32;

    // A pattern that stays in progress past this position swallows the key.
    localparam logic [POS_W-1:0] EAT_POS = POS_W'(2);

    // Configuration register addresses.
    localparam int APB_AW = 3;
    localparam logic [APB_AW-1:0] REG_ENABLE_ADDR = 3'd0;
    localparam logic [APB_AW-1:0] REG_COUNT_ADDR  = 3'd4;

    // Input word kinds.
    typedef enum logic [1:0] {
        MODE_KEY       = 2'd0,
        MODE_LOAD_CHAR = 2'd1,
        MODE_LOAD_FLAG = 2'd2,
        MODE_UNUSED    = 2'd3
    } t_mode;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_EMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              capture;
        logic              scan_start;
        logic              load;
        logic              issue;
        logic [SLOT_W-1:0] issue_slot;
        logic              emit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic stage_busy;
        logic out_free;
        logic emit_last;
    } t_status;

    // Fold lower-case letters to upper case.
    function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] c);
        if (c >= CH_LOW_A && c <= CH_LOW_Z) begin
            return c - CASE_OFS;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/kseq_ctrl.sv -----
// Controller state machine: sequences loads, the slot scan and result emission.
`default_nettype none

module kseq_ctrl
    import kseq_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic [1:0]       i_mode,
    input  wire logic [CNT_W-1:0] i_scan_count,
    input  wire t_status          i_status,
    output t_cmd                  o_cmd,
    output logic                  o_in_ready
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_iss, n_iss;
    logic             w_accept;
    logic             w_issue_more;

    assign o_in_ready   = (r_state == ST_IDLE);
    assign w_accept     = i_in_valid && o_in_ready;
    assign w_issue_more = (r_iss < i_scan_count);

    // State and issue counter registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_iss   <= '0;
        end else begin
            r_state <= n_state;
            r_iss   <= n_iss;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_mode) inside
                        MODE_LOAD_CHAR, MODE_LOAD_FLAG: n_state = ST_LOAD;
                        MODE_KEY:                       n_state = ST_SCAN;
                        default:                        n_state = ST_IDLE;
                    endcase
                end
            end
            ST_LOAD: begin
                n_state = ST_IDLE;
            end
            ST_SCAN: begin
                if (!w_issue_more && !i_status.stage_busy) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_status.out_free && i_status.emit_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Slot issue counter: restarts with each accepted word.
    always_comb begin
        n_iss = r_iss;
        if (w_accept) begin
            n_iss = '0;
        end else if (r_state == ST_SCAN && w_issue_more) begin
            n_iss = r_iss + CNT_W'(1);
        end
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd            = '0;
        o_cmd.capture    = w_accept;
        o_cmd.scan_start = w_accept && (i_mode == MODE_KEY);
        o_cmd.issue_slot = r_iss[SLOT_W-1:0];
        case (r_state)
            ST_LOAD: o_cmd.load  = 1'b1;
            ST_SCAN: o_cmd.issue = w_issue_more;
            ST_EMIT: o_cmd.emit  = i_status.out_free;
            default: o_cmd.load  = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/kseq_dp.sv -----
// Datapath: pattern memory, per-slot match state, result queue and output register.
`default_nettype none

module kseq_dp
    import kseq_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_cmd,
    output t_status                o_status,
    // Input word fields
    input  wire logic [1:0]        i_mode,
    input  wire logic [CHAR_W-1:0] i_key,
    input  wire logic [SLOT_W-1:0] i_pattern_index,
    input  wire logic [POS_W-1:0]  i_char_position,
    input  wire logic [CHAR_W-1:0] i_char_value,
    input  wire logic              i_skip_mode_check,
    input  wire logic              i_cheat_mode_ok,
    // Result word
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    output logic                   o_fired,
    output logic [SLOT_W-1:0]      o_fired_pattern,
    output logic [ARG_W-1:0]       o_arg_first,
    output logic [ARG_W-1:0]       o_arg_second,
    output logic                   o_eat,
    output logic                   o_last
);

    // Captured input word.
    t_mode             r_mode;
    logic [CHAR_W-1:0] r_key;
    logic [SLOT_W-1:0] r_pidx;
    logic [POS_W-1:0]  r_cpos;
    logic [CHAR_W-1:0] r_cval;
    logic              r_skip;
    logic              r_cheat;

    // Pattern memory with one valid bit per entry.
    logic [CHAR_W-1:0]    r_mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] r_mvalid;
    logic [CHAR_W-1:0]    r_rda, r_rdb;
    logic                 r_va, r_vb;

    // Per-slot state.
    logic [POS_W-1:0] r_mpos [NUM_PAT];
    logic [CC_W-1:0]  r_ccnt [NUM_PAT];
    logic [ARG_W-1:0] r_dig0 [NUM_PAT];
    logic [ARG_W-1:0] r_dig1 [NUM_PAT];
    logic [NUM_PAT-1:0] r_bypass;

    // Compare stage.
    logic              r_cv;
    logic [SLOT_W-1:0] r_cslot;
    logic [POS_W-1:0]  r_spos;
    logic              r_cend;

    // Result queue and emission.
    logic [SLOT_W-1:0] r_qslot [MAX_RESULTS];
    logic [ARG_W-1:0]  r_qa0   [MAX_RESULTS];
    logic [ARG_W-1:0]  r_qa1   [MAX_RESULTS];
    logic [CNT_W-1:0]  r_qcnt;
    logic [CNT_W-1:0]  r_rp;
    logic              r_eat;

    // Output register.
    logic              r_ovalid;
    logic              r_ofired;
    logic [SLOT_W-1:0] r_oslot;
    logic [ARG_W-1:0]  r_oa0, r_oa1;
    logic              r_oeat, r_olast;

    logic [POS_W-1:0]  w_iss_pos;
    logic [MEM_AW-1:0] w_addr_a, w_addr_b, w_waddr;
    logic [CHAR_W-1:0] w_c, w_nx, w_kdiff;
    logic [CC_W-1:0]   w_cc;
    logic              w_is_digit, w_is_space, w_active, w_wild, w_match, w_adv;
    logic              w_done, w_capture, w_push, w_eat_add;
    logic [POS_W-1:0]  w_npos;
    logic [ARG_W-1:0]  w_val, w_d0, w_d1;
    logic              w_emit_fired;

    // Capture the accepted word.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode  <= t_mode'(i_mode);
            r_key   <= i_key;
            r_pidx  <= i_pattern_index;
            r_cpos  <= i_char_position;
            r_cval  <= i_char_value;
            r_skip  <= i_skip_mode_check;
            r_cheat <= i_cheat_mode_ok;
        end
    end

    // Read addresses: current character and the one after it.
    assign w_iss_pos = r_mpos[i_cmd.issue_slot];
    assign w_addr_a  = {i_cmd.issue_slot, w_iss_pos};
    assign w_addr_b  = {i_cmd.issue_slot, w_iss_pos + POS_W'(1)};
    assign w_waddr   = {r_pidx, r_cpos};

    // Memory write and the two registered reads.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && r_mode == MODE_LOAD_CHAR) begin
            r_mem[w_waddr] <= r_cval;
        end
        if (i_cmd.issue) begin
            r_rda   <= r_mem[w_addr_a];
            r_rdb   <= r_mem[w_addr_b];
            r_va    <= r_mvalid[w_addr_a];
            r_vb    <= r_mvalid[w_addr_b];
            r_cslot <= i_cmd.issue_slot;
            r_spos  <= w_iss_pos;
            r_cend  <= (w_iss_pos == POS_W'(MAX_LEN - 1));
        end
    end

    // Entry valid bits: an unwritten entry reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvalid <= '0;
        end else if (i_cmd.load && r_mode == MODE_LOAD_CHAR) begin
            r_mvalid[w_waddr] <= 1'b1;
        end
    end

    // Compare stage valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv <= 1'b0;
        end else begin
            r_cv <= i_cmd.issue;
        end
    end

    // Match step for the slot in the compare stage.
    assign w_c        = r_va ? r_rda : '0;
    assign w_nx       = r_vb ? r_rdb : '0;
    assign w_cc       = r_ccnt[r_cslot];
    assign w_is_digit = (r_key >= CH_ZERO) && (r_key <= CH_NINE);
    assign w_is_space = (r_key == CH_SPACE);
    assign w_kdiff    = r_key - CH_ZERO;
    assign w_val      = w_is_space ? '0 : w_kdiff[ARG_W-1:0];
    assign w_active   = r_cv && (w_c != '0);
    assign w_wild     = (w_c == CH_HASH) && (w_is_digit || w_is_space);
    assign w_match    = (fold(r_key) == fold(w_c));
    assign w_adv      = w_wild || w_match;
    assign w_npos     = r_spos + POS_W'(1);
    assign w_done     = w_adv && (r_cend || w_nx == '0);
    assign w_capture  = w_active && w_wild && (w_cc < CC_W'(ARG_SLOTS));
    assign w_d0       = (w_capture && w_cc == CC_W'(0)) ? w_val : r_dig0[r_cslot];
    assign w_d1       = (w_capture && w_cc == CC_W'(1)) ? w_val : r_dig1[r_cslot];
    assign w_push     = w_active && w_done && (r_bypass[r_cslot] || r_cheat)
                        && (r_qcnt < CNT_W'(MAX_RESULTS));

    // Swallow decision contributed by this slot.
    always_comb begin
        w_eat_add = 1'b0;
        if (r_cv) begin
            if (w_c == '0) begin
                w_eat_add = (r_spos > EAT_POS);
            end else if (w_wild) begin
                w_eat_add = 1'b1;
            end else if (w_adv && !w_done) begin
                w_eat_add = (w_npos > EAT_POS);
            end
        end
    end

    // Per-slot state update: loads restart a slot, the scan advances it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_PAT; i++) begin
                r_mpos[i] <= '0;
                r_ccnt[i] <= '0;
                r_dig0[i] <= '0;
                r_dig1[i] <= '0;
            end
            r_bypass <= '0;
        end else begin
            if (i_cmd.load) begin
                if (r_mode == MODE_LOAD_FLAG) begin
                    r_bypass[r_pidx] <= r_skip;
                end
                r_mpos[r_pidx] <= '0;
                r_ccnt[r_pidx] <= '0;
            end
            if (w_active) begin
                r_dig0[r_cslot] <= w_d0;
                r_dig1[r_cslot] <= w_d1;
                if (w_adv && !w_done) begin
                    r_mpos[r_cslot] <= w_npos;
                    if (w_capture) begin
                        r_ccnt[r_cslot] <= w_cc + CC_W'(1);
                    end
                end else begin
                    r_mpos[r_cslot] <= '0;
                    r_ccnt[r_cslot] <= '0;
                end
            end
        end
    end

    // Result queue contents.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_qslot[r_qcnt[SLOT_W-1:0]] <= r_cslot;
            r_qa0[r_qcnt[SLOT_W-1:0]]   <= w_d0;
            r_qa1[r_qcnt[SLOT_W-1:0]]   <= w_d1;
        end
    end

    // Queue fill, read pointer and swallow flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qcnt <= '0;
            r_rp   <= '0;
            r_eat  <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_qcnt <= '0;
            r_rp   <= '0;
            r_eat  <= 1'b0;
        end else begin
            if (w_push) begin
                r_qcnt <= r_qcnt + CNT_W'(1);
            end
            if (w_eat_add) begin
                r_eat <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_rp <= r_rp + CNT_W'(1);
            end
        end
    end

    assign w_emit_fired = (r_qcnt != '0);

    // Output register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    // Output register word.
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_ofired <= w_emit_fired;
            r_oslot  <= w_emit_fired ? r_qslot[r_rp[SLOT_W-1:0]] : '0;
            r_oa0    <= w_emit_fired ? r_qa0[r_rp[SLOT_W-1:0]] : '0;
            r_oa1    <= w_emit_fired ? r_qa1[r_rp[SLOT_W-1:0]] : '0;
            r_oeat   <= r_eat;
            r_olast  <= o_status.emit_last;
        end
    end

    // Status to the controller.
    assign o_status.stage_busy = r_cv;
    assign o_status.out_free   = !r_ovalid || i_out_ready;
    assign o_status.emit_last  = !w_emit_fired || (r_rp == r_qcnt - CNT_W'(1));

    assign o_out_valid     = r_ovalid;
    assign o_fired         = r_ofired;
    assign o_fired_pattern = r_oslot;
    assign o_arg_first     = r_oa0;
    assign o_arg_second    = r_oa1;
    assign o_eat           = r_oeat;
    assign o_last          = r_olast;

endmodule

`default_nettype wire

// ----- rtl/core/multi_pattern_key_sequence_matcher.sv -----
// Top level of the key sequence matcher: configuration registers, stream ports and assertions.
//
// Input stream (s_axis): one word per keystroke or pattern load; tuser carries the mode.
// Modes: keystroke, load one pattern character, load a pattern's bypass flag.
// Output stream (m_axis): a keystroke gives one word per fired pattern in slot order,
// or a single word with fired low when none fires; tlast marks its final word.
// Loads and the unused mode give no output word.
// Keystroke: the block scans N slots and then emits its output words from the result
// queue, N being the number of scanned slots (pattern_count capped at 8, zero when disabled);
// the block is ready again in the cycle after it issues the final output word. The scan
// walks one slot per cycle, set by the pattern memory, which reads a slot's current and
// next character together.
// A load is written in the load state, after which the block is idle again. One word is
// worked on at a time; s_axis_tready is high only while the block is idle, and the final
// output word may wait in the output register while the next input word is taken.
// A stalled receiver holds m_axis_tvalid and the word; emission pauses until tready.
// Reset (synchronous, active low) clears all patterns, progress, digits and flags,
// sets matching_enabled to 1 and pattern_count to 0.
// Configuration: APB registers matching_enabled at 0x0 and pattern_count at 0x4, which the
// user is to write only while the block is idle; the block itself does not enforce this.
`default_nettype none

`include "assert_macros.svh"

module multi_pattern_key_sequence_matcher
    import kseq_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // Configuration port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    // Input stream
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    // key[7:0], pattern_index[10:8], char_position[14:11], char_value[22:15],
    // skip_mode_check[23], cheat_mode_ok[24], zero[31:25]
    input  wire logic [31:0]       s_axis_tdata,
    // mode[1:0]
    input  wire logic [1:0]        s_axis_tuser,
    // Output stream
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    // fired_pattern[2:0], arg_first[6:3], arg_second[10:7], eat[11], zero[15:12]
    output logic [15:0]            m_axis_tdata,
    // fired[0]
    output logic                   m_axis_tuser,
    output logic                   m_axis_tlast
);

    logic             r_enable;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] w_scan_count;
    logic             w_cfg_write;
    logic             w_in_accept;
    t_cmd             w_cmd;
    t_status          w_st;

    logic              w_fired;
    logic [SLOT_W-1:0] w_fired_pattern;
    logic [ARG_W-1:0]  w_arg_first, w_arg_second;
    logic              w_eat;

    logic              w_key_acc;
    logic              w_nofire;
    logic              w_nofire_ok;

    // Configuration registers.
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b1;
            r_count  <= '0;
        end else if (w_cfg_write) begin
            case (paddr)
                REG_ENABLE_ADDR: r_enable <= pwdata[0];
                REG_COUNT_ADDR:  r_count  <= pwdata[CNT_W-1:0];
                default:         r_enable <= r_enable;
            endcase
        end
    end

    // Register read back.
    always_comb begin
        case (paddr)
            REG_ENABLE_ADDR: prdata = {31'b0, r_enable};
            REG_COUNT_ADDR:  prdata = {{(32 - CNT_W){1'b0}}, r_count};
            default:         prdata = '0;
        endcase
    end

    // Number of slots scanned per keystroke.
    always_comb begin
        if (!r_enable) begin
            w_scan_count = '0;
        end else if (r_count > CNT_W'(NUM_PAT)) begin
            w_scan_count = CNT_W'(NUM_PAT);
        end else begin
            w_scan_count = r_count;
        end
    end

    assign w_in_accept = s_axis_tvalid && s_axis_tready;

    kseq_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_mode       (s_axis_tuser),
        .i_scan_count (w_scan_count),
        .i_status     (w_st),
        .o_cmd        (w_cmd),
        .o_in_ready   (s_axis_tready)
    );

    kseq_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_status          (w_st),
        .i_mode            (s_axis_tuser),
        .i_key             (s_axis_tdata[7:0]),
        .i_pattern_index   (s_axis_tdata[10:8]),
        .i_char_position   (s_axis_tdata[14:11]),
        .i_char_value      (s_axis_tdata[22:15]),
        .i_skip_mode_check (s_axis_tdata[23]),
        .i_cheat_mode_ok   (s_axis_tdata[24]),
        .i_out_ready       (m_axis_tready),
        .o_out_valid       (m_axis_tvalid),
        .o_fired           (w_fired),
        .o_fired_pattern   (w_fired_pattern),
        .o_arg_first       (w_arg_first),
        .o_arg_second      (w_arg_second),
        .o_eat             (w_eat),
        .o_last            (m_axis_tlast)
    );

    // Pack the output word.
    assign m_axis_tuser = w_fired;
    assign m_axis_tdata = {4'b0, w_eat, w_arg_second, w_arg_first, w_fired_pattern};

    // Terms used by the checks below.
    assign w_key_acc   = w_in_accept && (s_axis_tuser == MODE_KEY);
    assign w_nofire    = m_axis_tvalid && !m_axis_tuser;
    assign w_nofire_ok = m_axis_tlast && (m_axis_tdata[10:0] == 11'd0);

    // A keystroke keeps the block busy in the following cycle.
    `ASSERT_NEXT(a_key_busy, i_clk, i_rst_n, w_key_acc, !s_axis_tready, "ready after a key")

    // The block only takes a word when the compare stage is empty.
    `ASSERT_IMPLIES(a_rdy_idle, i_clk, i_rst_n, s_axis_tready, !w_st.stage_busy, "stage busy")

    // A word without a fired pattern is the only word of its keystroke and carries no slot.
    `ASSERT_IMPLIES(a_nofire_word, i_clk, i_rst_n, w_nofire, w_nofire_ok, "bad non-fired word")

endmodule

`default_nettype wire
